// ===== hdl/stt_pkg.sv =====
package stt_pkg;

    localparam int MaxEntriesDefault = 64;
    localparam int IndexBitsDefault  = 8;
    localparam int IdxW              = 8;
    localparam int DimW              = 9;
    localparam int ValW              = 32;

    // register indexes of the configuration port
    localparam logic CFG_SOURCE_ROWS = 1'b0;
    localparam logic CFG_SOURCE_COLS = 1'b1;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // one input beat
    typedef struct packed {
        logic [IdxW-1:0]        entry_row;
        logic [IdxW-1:0]        entry_col;
        logic signed [ValW-1:0] entry_value;
        logic                   last_entry;
    } t_in;

    // one result beat
    typedef struct packed {
        logic [IdxW-1:0]        out_row;
        logic [IdxW-1:0]        out_col;
        logic signed [ValW-1:0] out_value;
        logic                   out_last;
        logic [DimW-1:0]        result_rows;
        logic [DimW-1:0]        result_cols;
        logic                   overflow;
    } t_out;

    // stored triplet, row and column already swapped
    typedef struct packed {
        logic [IdxW-1:0]        r;
        logic [IdxW-1:0]        c;
        logic signed [ValW-1:0] v;
    } t_trip;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctl;

endpackage

// ===== hdl/stt_cell.sv =====
module stt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stt_pkg::t_cell_ctl i_ctl,
    input  stt_pkg::t_trip    i_new,
    input  stt_pkg::t_trip    i_left,
    input  logic              i_left_valid,
    input  logic              i_left_gt,
    input  stt_pkg::t_trip    i_right,
    input  logic              i_right_valid,
    output stt_pkg::t_trip    o_data,
    output logic              o_valid,
    output logic              o_gt
);
    import stt_pkg::*;

    t_trip r_data;
    t_trip n_data;
    logic  r_valid;
    logic  n_valid;

    // an empty cell counts as larger than any key, so it takes part in the shift
    assign o_gt = !r_valid || ({r_data.r, r_data.c} > {i_new.r, i_new.c});

    // insert: the first larger cell takes the new triplet, the rest move right
    // shift_out: everything moves one cell toward the head
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.shift_out) begin
            n_data  = i_right;
            n_valid = i_right_valid;
        end else if (i_ctl.insert && o_gt) begin
            if (i_left_gt) begin
                n_data  = i_left;
                n_valid = i_left_valid;
            end else begin
                n_data  = i_new;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== hdl/sparse_triplet_transpose_sorter.sv =====
// Sparse matrix transpose with sorted emission, triplet form.
// Input: one (row, col, value) beat is taken on a clock edge with start high
// and busy low; last_entry marks the final beat of a matrix. Each beat is
// swapped (row <-> col) and inserted into a chain of MAX_ENTRIES sorting
// cells, ordered by new row then new column, equal keys behind the ones
// already stored. Beats arriving with the chain full are dropped and the
// overflow flag is set for that matrix.
// Output: after the last beat busy goes high; the head cell shifts out one
// triplet per cycle, registered: the state register turns to emit, then
// the strobe and result registers present each head triplet, and n results
// follow back to back with out_last on the final one. busy drops in the
// cycle of the last strobe. New beats are held off by busy while the chain
// empties; the last strobe overlaps the first beat of the next matrix.
// Results cannot be held off: each result is shown for exactly one cycle.
// Configuration (source_rows, source_cols) is to be written by the user
// only while idle; the block itself does not enforce it.
// Reset empties the chain, clears overflow and sets both dimensions to 256.
module sparse_triplet_transpose_sorter #(
    parameter int MAX_ENTRIES = stt_pkg::MaxEntriesDefault,
    parameter int INDEX_BITS  = stt_pkg::IndexBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  stt_pkg::t_in              i_item,
    output logic                      o_strobe,
    output stt_pkg::t_out             o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [stt_pkg::DimW-1:0]  i_cfg_data
);
    import stt_pkg::*;

    localparam logic [16:0]     FullMask = (17'd1 << INDEX_BITS) - 17'd1;
    localparam logic [IdxW-1:0] IdxMask  = FullMask[IdxW-1:0];

    t_state          r_state;
    t_state          n_state;
    logic            r_ovf;
    logic            n_ovf;
    logic [DimW-1:0] r_src_rows;
    logic [DimW-1:0] r_src_cols;
    logic            r_strobe;
    t_out            r_out;
    t_out            n_out;

    logic            accept;
    logic            full;
    t_cell_ctl       ctl;
    t_trip           new_trip;

    t_trip                  w_data [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_gt;

    assign full     = w_valid[MAX_ENTRIES-1];
    assign accept   = start && !busy;
    assign new_trip = '{r: i_item.entry_col & IdxMask,
                        c: i_item.entry_row & IdxMask,
                        v: i_item.entry_value};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rows <= DimW'(256);
            r_src_cols <= DimW'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_ROWS: r_src_rows <= i_cfg_data;
                CFG_SOURCE_COLS: r_src_cols <= i_cfg_data;
                default:         r_src_rows <= r_src_rows;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (accept && i_item.last_entry) n_state = ST_EMIT;
            ST_EMIT: if (!w_valid[1]) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        busy          = 1'b0;
        ctl.insert    = 1'b0;
        ctl.shift_out = 1'b0;
        unique case (r_state)
            ST_LOAD: ctl.insert = accept && !full;
            ST_EMIT: begin
                busy          = 1'b1;
                ctl.shift_out = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    // overflow flag, cleared once the burst is out
    always_comb begin
        n_ovf = r_ovf;
        if (accept && full) begin
            n_ovf = 1'b1;
        end else if (r_state == ST_EMIT && !w_valid[1]) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovf    <= n_ovf;
            r_strobe <= ctl.shift_out;
        end
    end

    // result beat taken from the head cell
    always_comb begin
        n_out.out_row     = w_data[0].r;
        n_out.out_col     = w_data[0].c;
        n_out.out_value   = w_data[0].v;
        n_out.out_last    = !w_valid[1];
        n_out.result_rows = r_src_cols;
        n_out.result_cols = r_src_rows;
        n_out.overflow    = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // sorting chain
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        t_trip left_data;
        logic  left_valid;
        logic  left_gt;
        t_trip right_data;
        logic  right_valid;

        if (i == 0) begin : g_head
            assign left_data  = new_trip;
            assign left_valid = 1'b0;
            assign left_gt    = 1'b0;
        end else begin : g_body
            assign left_data  = w_data[i-1];
            assign left_valid = w_valid[i-1];
            assign left_gt    = w_gt[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_data  = w_data[i+1];
            assign right_valid = w_valid[i+1];
        end

        stt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new         (new_trip),
            .i_left        (left_data),
            .i_left_valid  (left_valid),
            .i_left_gt     (left_gt),
            .i_right       (right_data),
            .i_right_valid (right_valid),
            .o_data        (w_data[i]),
            .o_valid       (w_valid[i]),
            .o_gt          (w_gt[i])
        );
    end

    // occupied cells always form one run from the head
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MAX_ENTRIES'(1))) == '0)
        else $error("chain has a hole");

    // a result only follows an emit cycle
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("strobe without emit");

    // the final result ends the burst
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_last) |-> !busy)
        else $error("busy after final result");

    // a beat taken while full raises overflow
    a_ovf_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full) |=> r_ovf)
        else $error("dropped beat not flagged");

    // the emit burst never starts on an empty chain
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_valid[0])
        else $error("emit with empty chain");

endmodule
